### rtl/assert_macros.svh
// assertion macros shared by the rtl modules
// no dependencies; expands to nothing when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MBD_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define MBD_ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`else
`define MBD_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define MBD_ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`endif
`endif

### rtl/mbd_pkg.sv
// types, constants and channel arithmetic for the mip box downsampler
// no dependencies
package mbd_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int WL2_MAX    = $clog2(MAX_WIDTH + 1) - 1;
    localparam int COL_W      = WL2_MAX;
    localparam int LINE_AW    = WL2_MAX - 1;
    localparam int LINE_DEPTH = 2 ** LINE_AW;
    localparam int ROW_W      = 15;
    localparam int LANE_W     = 9;
    localparam int LINE_W     = 4 * LANE_W;
    localparam int PIX_W      = 32;
    localparam int CFG_AW     = 2;
    localparam int CFG_DW     = 4;

    localparam logic [1:0] FMT_RGB888   = 2'd0;
    localparam logic [1:0] FMT_RGBA8888 = 2'd1;
    localparam logic [1:0] FMT_RGB5551  = 2'd2;

    localparam logic [CFG_AW-1:0] REG_FMT = 2'd0;
    localparam logic [CFG_AW-1:0] REG_WL2 = 2'd1;
    localparam logic [CFG_AW-1:0] REG_HL2 = 2'd2;

    typedef enum logic [2:0] {
        K_HOLD,
        K_STORE,
        K_PASS,
        K_PAIR,
        K_QUAD
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [PIX_W-1:0]   a;
        logic [PIX_W-1:0]   b;
        logic [LINE_AW-1:0] idx;
        logic               last;
        logic [1:0]         fmt;
    } t_s1;

    function automatic logic [2:0] num_chan(logic [1:0] fmt);
        return (fmt == FMT_RGB888 || fmt == FMT_RGB5551) ? 3'd3 : 3'd4;
    endfunction

    function automatic logic [7:0] chan_get(logic [PIX_W-1:0] p, int unsigned i, logic f5);
        logic [PIX_W-1:0] sh;
        sh = f5 ? (p >> (1 + 5 * i)) : (p >> (8 * i));
        return f5 ? {3'b000, sh[4:0]} : sh[7:0];
    endfunction

    function automatic logic [PIX_W-1:0] chan_put(logic [7:0] v, int unsigned i, logic f5);
        return f5 ? (PIX_W'(v[4:0]) << (1 + 5 * i)) : (PIX_W'(v) << (8 * i));
    endfunction

    function automatic logic [LINE_W-1:0] pair_sum(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b,
                                                   logic [1:0] fmt);
        logic [LINE_W-1:0] r;
        logic              f5;
        logic [2:0]        nch;
        r   = '0;
        f5  = (fmt == FMT_RGB5551);
        nch = num_chan(fmt);
        for (int unsigned i = 0; i < 4; i++) begin
            if (i < nch) begin
                r[LANE_W*i +: LANE_W] = LANE_W'(chan_get(a, i, f5)) + LANE_W'(chan_get(b, i, f5));
            end
        end
        return r;
    endfunction

    function automatic logic [PIX_W-1:0] avg_pixel(logic [LINE_W-1:0] lanes,
                                                   logic [PIX_W-1:0] a, logic [PIX_W-1:0] b,
                                                   t_kind kind, logic [1:0] fmt);
        logic [PIX_W-1:0] res;
        logic             f5;
        logic [2:0]       nch;
        logic [10:0]      s;
        logic [10:0]      t;
        logic [7:0]       v;
        res = '0;
        f5  = (fmt == FMT_RGB5551);
        nch = num_chan(fmt);
        for (int unsigned i = 0; i < 4; i++) begin
            s = 11'(chan_get(a, i, f5)) + 11'(chan_get(b, i, f5));
            case (kind)
                K_PASS: v = chan_get(a, i, f5);
                K_PAIR: begin
                    t = f5 ? (s >> 1) : ((s + 11'd1) >> 1);
                    v = t[7:0];
                end
                K_QUAD: begin
                    t = s + 11'(lanes[LANE_W*i +: LANE_W]);
                    t = f5 ? (t >> 2) : ((t + 11'd2) >> 2);
                    v = t[7:0];
                end
                default: v = '0;
            endcase
            if (i < nch) begin
                res = res | chan_put(v, i, f5);
            end
        end
        return res;
    endfunction

endpackage

### rtl/mbd_src_if.sv
// source pixel request channel
// no dependencies
interface mbd_src_if;
    logic        valid;
    logic        ready;
    logic [31:0] src_pixel;

    modport source (output valid, output src_pixel, input ready);
    modport sink (input valid, input src_pixel, output ready);
endinterface

### rtl/mbd_mip_if.sv
// destination pixel request channel
// no dependencies
interface mbd_mip_if;
    logic        valid;
    logic        ready;
    logic [31:0] mip_pixel;
    logic        last_of_level;

    modport source (output valid, output mip_pixel, output last_of_level, input ready);
    modport sink (input valid, input mip_pixel, input last_of_level, output ready);
endinterface

### rtl/mbd_line_buf.sv
// line buffer for the pair sums of even source rows
// depends on mbd_pkg
module mbd_line_buf
    import mbd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rd_en,
    input  logic [LINE_AW-1:0] i_rd_addr,
    input  logic               i_wr_en,
    input  logic [LINE_AW-1:0] i_wr_addr,
    input  logic [LINE_W-1:0]  i_wr_data,
    output logic [LINE_W-1:0]  o_rd_data
);

    logic [LINE_W-1:0] r_mem [LINE_DEPTH];
    logic [LINE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/mbd_front.sv
// input stage: configuration registers, position counters, held pixel, input register
// depends on mbd_pkg and assert_macros.svh
`include "assert_macros.svh"
module mbd_front
    import mbd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CFG_AW-1:0]  i_cfg_idx,
    input  logic [CFG_DW-1:0]  i_cfg_data,
    input  logic               i_valid,
    input  logic [PIX_W-1:0]   i_pixel,
    output logic               o_ready,
    output logic               o_rd_en,
    output logic [LINE_AW-1:0] o_rd_addr,
    output logic               o_s1_valid,
    output t_s1                o_s1,
    input  logic               i_s1_take
);

    logic [1:0]       r_fmt;
    logic [3:0]       r_wl2;
    logic [3:0]       r_hl2;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [PIX_W-1:0] r_held;
    logic             r_s1_valid;
    t_s1              r_s1;

    logic [3:0]       wl2_eff;
    logic [COL_W-1:0] w_m1;
    logic [ROW_W-1:0] h_m1;
    logic             cfg_hit;
    logic             accept;
    logic             last;
    t_kind            kind;
    logic [COL_W-1:0] n_col;
    logic [ROW_W-1:0] n_row;

    assign wl2_eff = (r_wl2 > 4'(WL2_MAX)) ? 4'(WL2_MAX) : r_wl2;
    assign w_m1    = COL_W'({COL_W{1'b1}} >> (4'(WL2_MAX) - wl2_eff));
    assign h_m1    = ROW_W'({ROW_W{1'b1}} >> (4'(ROW_W) - r_hl2));
    assign cfg_hit = i_cfg_we && (i_cfg_idx inside {REG_FMT, REG_WL2, REG_HL2});
    assign o_ready = !r_s1_valid || i_s1_take;
    assign accept  = i_valid && o_ready;
    assign last    = (r_col == w_m1) && (r_row == h_m1);

    always_comb begin
        if (wl2_eff == '0 && r_hl2 == '0) begin
            kind = K_PASS;
        end else if (r_hl2 == '0) begin
            kind = r_col[0] ? K_PAIR : K_HOLD;
        end else if (wl2_eff == '0) begin
            kind = r_row[0] ? K_PAIR : K_HOLD;
        end else if (!r_col[0]) begin
            kind = K_HOLD;
        end else if (!r_row[0]) begin
            kind = K_STORE;
        end else begin
            kind = K_QUAD;
        end
    end

    always_comb begin
        n_col = r_col + COL_W'(1);
        n_row = r_row;
        if (r_col == w_m1) begin
            n_col = '0;
            n_row = (r_row == h_m1) ? '0 : r_row + ROW_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt      <= FMT_RGB888;
            r_wl2      <= '0;
            r_hl2      <= '0;
            r_col      <= '0;
            r_row      <= '0;
            r_held     <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_FMT: r_fmt <= i_cfg_data[1:0];
                    REG_WL2: r_wl2 <= i_cfg_data;
                    REG_HL2: r_hl2 <= i_cfg_data;
                    default: ;
                endcase
            end
            if (cfg_hit) begin
                r_col <= '0;
                r_row <= '0;
            end else if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (accept && kind == K_HOLD) begin
                r_held <= i_pixel;
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (i_s1_take) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1.kind <= kind;
            r_s1.a    <= (kind == K_PASS) ? i_pixel : r_held;
            r_s1.b    <= i_pixel;
            r_s1.idx  <= r_col[COL_W-1:1];
            r_s1.last <= last;
            r_s1.fmt  <= r_fmt;
        end
    end

    assign o_rd_en    = accept;
    assign o_rd_addr  = r_col[COL_W-1:1];
    assign o_s1_valid = r_s1_valid;
    assign o_s1       = r_s1;

    `MBD_ASSERT_ALWAYS(a_pos_in_range, i_clk, i_rst_n, (r_col <= w_m1) && (r_row <= h_m1), "position beyond level size")
    `MBD_ASSERT_PROP(a_level_wrap, i_clk, i_rst_n, (accept && last && !cfg_hit) |=> (r_col == '0 && r_row == '0), "counters did not wrap after last pixel")
    `MBD_ASSERT_PROP(a_pass_is_last, i_clk, i_rst_n, (r_s1_valid && r_s1.kind == K_PASS) |-> r_s1.last, "single pixel level not marked last")

endmodule

### rtl/mbd_back.sv
// averaging stage and output register, plus line buffer write of pair sums
// depends on mbd_pkg and assert_macros.svh
`include "assert_macros.svh"
module mbd_back
    import mbd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s1_valid,
    input  t_s1                i_s1,
    output logic               o_s1_take,
    input  logic [LINE_W-1:0]  i_rd_data,
    output logic               o_wr_en,
    output logic [LINE_AW-1:0] o_wr_addr,
    output logic [LINE_W-1:0]  o_wr_data,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [PIX_W-1:0]   o_pixel,
    output logic               o_last
);

    logic             r_s2_valid;
    logic [PIX_W-1:0] r_s2_pix;
    logic             r_s2_last;

    logic             emits;
    logic             s2_free;
    logic             fire;

    assign emits     = (i_s1.kind == K_PASS) || (i_s1.kind == K_PAIR) || (i_s1.kind == K_QUAD);
    assign s2_free   = !r_s2_valid || i_ready;
    assign o_s1_take = i_s1_valid && (!emits || s2_free);
    assign fire      = o_s1_take && emits;

    assign o_wr_en   = o_s1_take && (i_s1.kind == K_STORE);
    assign o_wr_addr = i_s1.idx;
    assign o_wr_data = pair_sum(i_s1.a, i_s1.b, i_s1.fmt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (fire) begin
            r_s2_valid <= 1'b1;
        end else if (i_ready) begin
            r_s2_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_s2_pix  <= avg_pixel(i_rd_data, i_s1.a, i_s1.b, i_s1.kind, i_s1.fmt);
            r_s2_last <= i_s1.last;
        end
    end

    assign o_valid = r_s2_valid;
    assign o_pixel = r_s2_pix;
    assign o_last  = r_s2_last;

    `MBD_ASSERT_PROP(a_fire_shows, i_clk, i_rst_n, fire |=> r_s2_valid, "averaged pixel not presented")
    `MBD_ASSERT_PROP(a_no_overwrite, i_clk, i_rst_n, (r_s2_valid && !i_ready) |-> !fire, "pending result overwritten")

endmodule

### rtl/mip_box_downsample_core.sv
// top level of the 2x2 box filter mip level generator
// depends on mbd_pkg, mbd_src_if, mbd_mip_if, mbd_front, mbd_line_buf, mbd_back
//
// usage: write pixel_format (0), src_width_log2 (1) and src_height_log2 (2)
// through the cfg port while idle; each write restarts the level at pixel 0,0.
// source pixels come on i_src in raster order, one request per pixel, and
// destination pixels leave on o_mip in raster order, last_of_level marking
// the final one. after the last source pixel a new level of the same size
// begins with the next request.
// a source request is taken every cycle while o_mip takes its results; a result
// passes the input register, then the output register, before it reaches o_mip.
// with width w and height both above one, w/2 results come on every odd row
// only; a one pixel wide source gives one result per odd row and a one row high
// source one result per pixel pair. the even row pair sums wait in a 1024 x 36
// line buffer, read as the request is taken into the input register.
// when o_mip is stalled the finished pixel holds and one more request is
// taken into the input register; requests that give no result keep flowing.
// reset clears the configuration, counters, held pixel and valid flags; the line buffer needs no clearing.
module mip_box_downsample_core
    import mbd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    mbd_src_if.sink           i_src,
    mbd_mip_if.source         o_mip,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_idx,
    input  logic [CFG_DW-1:0] i_cfg_data
);

    logic               rd_en;
    logic [LINE_AW-1:0] rd_addr;
    logic [LINE_W-1:0]  rd_data;
    logic               wr_en;
    logic [LINE_AW-1:0] wr_addr;
    logic [LINE_W-1:0]  wr_data;
    logic               s1_valid;
    t_s1                s1;
    logic               s1_take;

    mbd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_src.valid),
        .i_pixel    (i_src.src_pixel),
        .o_ready    (i_src.ready),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .o_s1_valid (s1_valid),
        .o_s1       (s1),
        .i_s1_take  (s1_take)
    );

    mbd_line_buf u_line_buf (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data)
    );

    mbd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s1_valid (s1_valid),
        .i_s1       (s1),
        .o_s1_take  (s1_take),
        .i_rd_data  (rd_data),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data),
        .o_valid    (o_mip.valid),
        .i_ready    (o_mip.ready),
        .o_pixel    (o_mip.mip_pixel),
        .o_last     (o_mip.last_of_level)
    );

endmodule
